// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the odometry RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DDO_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DDO_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Check that a condition holds at every clock edge out of reset.
`define DDO_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) 1'b1 |-> (cond)) \
        else $error(msg);

`endif

// ===== hdl/ddo_pkg.sv =====
// Shared constants, request types and the arctangent table of the odometry block.
package ddo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int COUNT_WIDTH  = 32;

    localparam int CORDIC_IDX_W = 5;
    localparam int CORDIC_W     = 34;
    localparam logic [31:0] CORDIC_K = 32'h26DD3B6A;

    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = 64;
    localparam int MUL_DIGIT_W = 4;
    localparam int MUL_DIGITS  = MUL_B_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    localparam int S_DATA_W   = 64;
    localparam int S_USER_W   = 1;
    localparam int M_DATA_W   = 80;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } ddo_mul_req_t;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } ddo_cor_req_t;

    // atan(2^-i) as a binary angle, 2^32 per turn
    function automatic logic [31:0] atan_lookup(input logic [CORDIC_IDX_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2F9;
            5'd15:   val = 32'h0000517C;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A2F;
            5'd19:   val = 32'h00000517;
            5'd20:   val = 32'h0000028B;
            5'd21:   val = 32'h00000145;
            5'd22:   val = 32'h000000A2;
            5'd23:   val = 32'h00000051;
            5'd24:   val = 32'h00000028;
            5'd25:   val = 32'h00000014;
            5'd26:   val = 32'h0000000A;
            5'd27:   val = 32'h00000005;
            5'd28:   val = 32'h00000002;
            5'd29:   val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/ddo_digit_mult.sv =====
// Digit-serial unsigned multiplier: one 4-bit digit of the serial operand per cycle.
module ddo_digit_mult (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ddo_pkg::ddo_mul_req_t         req,
    output logic                          busy,
    output logic [ddo_pkg::MUL_P_W-1:0]   product
);
    import ddo_pkg::*;

    localparam int SUM_W = MUL_A_W + MUL_DIGIT_W;

    logic [MUL_A_W-1:0]   a_reg, a_next;
    logic [MUL_A_W-1:0]   hi_reg, hi_next;
    logic [MUL_B_W-1:0]   lo_reg, lo_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [SUM_W-1:0]     sum;

    // partial product of the low digit, added to the upper half
    assign sum = SUM_W'(hi_reg) + SUM_W'(a_reg) * SUM_W'(lo_reg[MUL_DIGIT_W-1:0]);

    always_comb begin
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (req.start) begin
            a_next    = req.a;
            hi_next   = '0;
            lo_next   = req.b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift the finished digit into the low word
            hi_next  = sum[SUM_W-1:MUL_DIGIT_W];
            lo_next  = {sum[MUL_DIGIT_W-1:0], lo_reg[MUL_B_W-1:MUL_DIGIT_W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_DIGITS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign busy    = busy_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ===== hdl/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC giving Q2.30 sine and cosine of a binary angle.
module ddo_cordic (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ddo_pkg::ddo_cor_req_t req,
    output logic                  busy,
    output logic signed [31:0]    sin_q30,
    output logic signed [31:0]    cos_q30
);
    import ddo_pkg::*;

    localparam logic signed [CORDIC_W-1:0] ONE_Q30 = CORDIC_W'(64'sd1073741824);
    localparam logic signed [31:0]         QUARTER = 32'sh40000000;

    logic signed [CORDIC_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [CORDIC_IDX_W-1:0]    idx_reg, idx_next;
    logic                       busy_reg, busy_next, flip_reg, flip_next;
    logic signed [31:0]         ang_s;
    logic                       fold;
    logic [31:0]                ang_f;
    logic signed [CORDIC_W-1:0] xs, ys, at, xc, yc;

    always_comb begin
        ang_s = signed'(req.angle);
        // fold the back half-plane into the front one and negate the result
        fold  = (ang_s > QUARTER) || (ang_s < -QUARTER);
        ang_f = fold ? (req.angle ^ 32'h80000000) : req.angle;
        xs    = x_reg >>> idx_reg;
        ys    = y_reg >>> idx_reg;
        at    = signed'({{(CORDIC_W-32){1'b0}}, atan_lookup(idx_reg)});

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        flip_next = flip_reg;
        if (req.start) begin
            x_next    = signed'({{(CORDIC_W-32){1'b0}}, CORDIC_K});
            y_next    = '0;
            z_next    = CORDIC_W'(signed'(ang_f));
            idx_next  = '0;
            busy_next = 1'b1;
            flip_next = fold;
        end else if (busy_reg) begin
            if (!z_reg[CORDIC_W-1]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            idx_next = idx_reg + 1'b1;
            if (idx_reg == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    // clamp to unity, then undo the fold
    always_comb begin
        xc = (x_reg > ONE_Q30) ? ONE_Q30 : ((x_reg < -ONE_Q30) ? -ONE_Q30 : x_reg);
        yc = (y_reg > ONE_Q30) ? ONE_Q30 : ((y_reg < -ONE_Q30) ? -ONE_Q30 : y_reg);
        cos_q30 = flip_reg ? 32'(-xc) : 32'(xc);
        sin_q30 = flip_reg ? 32'(-yc) : 32'(yc);
    end

    assign busy = busy_reg;

endmodule

// ===== hdl/differential_drive_odometry.sv =====
// Top level of the differential-drive dead-reckoning odometry block.
// Each encoder sample request carries absolute left and right wheel counts; the block
// turns the 32-bit binary-angle heading by (right - left) delta times heading_gain / 256,
// then moves x by D*sin and y by D*cos of the new heading, where D is half the delta sum
// times distance_gain (Q8.24 mm per tick), keeping the sub-millimetre fraction for the
// next sample. A clear request (kind = 1) zeroes the stored counts and reports the pose.
// Every request gives exactly one result. An encoder sample makes four passes of the
// 4-bit digit-serial multiplier (heading, distance, x step, y step) and one run of the
// CORDIC, which does one rotation per cycle in parallel with the distance product; a
// clear request goes from idle straight to the output state. A new request is taken
// while the previous result still waits on m_tready.
// Gains are written over the APB port at byte addresses 0 (heading_gain) and 4
// (distance_gain) and should be written only while the block is idle.
`include "assert_macros.svh"
module differential_drive_odometry (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] left_count, [63:32] right_count
    input  logic [ddo_pkg::S_DATA_W-1:0]      s_tdata,
    // [0] kind
    input  logic [ddo_pkg::S_USER_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] pos_x_mm, [63:32] pos_y_mm, [79:64] heading_out
    output logic [ddo_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ddo_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ddo_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ddo_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import ddo_pkg::*;

    // register index codes, taken from the word address bit
    localparam logic REG_HEADING_GAIN  = 1'b0;
    localparam logic REG_DISTANCE_GAIN = 1'b1;

    // product slices
    localparam int HEAD_LSB = 8;
    localparam int HEAD_MSB = 39;
    localparam int DMAG_LSB = 1;
    localparam int DMAG_MSB = 63;
    localparam int STEP_LSB = 30;
    localparam int STEP_MSB = 92;

    localparam logic signed [24:0] FRAC_MIN = 25'sh1000000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HGO,
        S_HWAIT,
        S_TGO,
        S_TWAIT,
        S_SGO,
        S_SWAIT,
        S_SUM,
        S_POS,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [31:0] hg_reg, hg_next, dg_reg, dg_next;
    logic        cfg_wr;

    // odometry state
    logic [31:0]        prev_left_reg, prev_left_next, prev_right_reg, prev_right_next;
    logic [31:0]        heading_reg, heading_next;
    logic [31:0]        pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [24:0] frac_x_reg, frac_x_next, frac_y_reg, frac_y_next;
    logic               axis_reg, axis_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // working registers
    logic signed [32:0] diff_reg, diff_next, sum_reg, sum_next;
    logic [62:0]        dmag_reg, dmag_next;
    logic signed [63:0] step_reg, step_next;
    logic signed [64:0] acc_reg, acc_next;
    logic [31:0]        out_x_reg, out_y_reg;
    logic [15:0]        out_h_reg;
    logic               out_load;

    // request fields
    logic        in_kind;
    logic [31:0] in_left, in_right;

    // deltas
    logic [31:0]        dsub_l, dsub_r;
    logic signed [31:0] dl, dr;
    logic [32:0]        smag;

    // shared multiplier and the CORDIC
    ddo_mul_req_t         mul_req;
    ddo_cor_req_t         cor_req;
    logic                 mul_busy, cor_busy;
    logic [MUL_P_W-1:0]   mul_prod;
    logic signed [31:0]   cor_sin, cor_cos, trig_sel;
    logic                 trig_neg;
    logic [31:0]          trig_mag;
    logic [62:0]          step_m;
    logic signed [63:0]   step_mag;

    // fraction carry
    logic [23:0]        rem;
    logic               fix;
    logic [31:0]        whole;
    logic signed [24:0] frac_new, frac_sel;

    assign in_kind  = s_tuser[0];
    assign in_left  = s_tdata[31:0];
    assign in_right = s_tdata[63:32];

    // APB port with no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_DISTANCE_GAIN) ? dg_reg : hg_reg;

    always_comb begin
        hg_next = hg_reg;
        dg_next = dg_reg;
        if (cfg_wr) begin
            if (paddr[2] == REG_HEADING_GAIN) begin
                hg_next = pwdata;
            end else begin
                dg_next = pwdata;
            end
        end
    end

    // wheel deltas wrap at the encoder width and sign-extend
    always_comb begin
        dsub_l = in_left - prev_left_reg;
        dsub_r = in_right - prev_right_reg;
        dl     = 32'(signed'(dsub_l[COUNT_WIDTH-1:0]));
        dr     = 32'(signed'(dsub_r[COUNT_WIDTH-1:0]));
        smag   = sum_reg[32] ? 33'(-sum_reg) : 33'(sum_reg);
    end

    // pick the trig term for the axis in hand: sine drives x, cosine drives y
    always_comb begin
        trig_sel = axis_reg ? cor_cos : cor_sin;
        trig_neg = trig_sel[31];
        trig_mag = trig_neg ? 32'(-trig_sel) : 32'(trig_sel);
        step_m   = mul_prod[STEP_MSB:STEP_LSB];
        step_mag = signed'({1'b0, step_m});
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_req.start = (state_reg == S_HGO) || (state_reg == S_TGO) || (state_reg == S_SGO);
        case (state_reg)
            S_HGO: begin
                mul_req.a = hg_reg;
                mul_req.b = 64'(diff_reg);
            end
            S_TGO: begin
                mul_req.a = dg_reg;
                mul_req.b = {31'b0, smag};
            end
            default: begin
                mul_req.a = trig_mag;
                mul_req.b = {1'b0, dmag_reg};
            end
        endcase
        cor_req.start = (state_reg == S_TGO);
        cor_req.angle = heading_reg;
    end

    ddo_digit_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .busy    (mul_busy),
        .product (mul_prod)
    );

    ddo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cor_req),
        .busy    (cor_busy),
        .sin_q30 (cor_sin),
        .cos_q30 (cor_cos)
    );

    // whole millimetres by truncation toward zero; the signed remainder stays
    always_comb begin
        rem      = acc_reg[23:0];
        fix      = acc_reg[64] && (rem != '0);
        whole    = acc_reg[55:24] + {31'b0, fix};
        frac_new = signed'({fix, rem});
        frac_sel = axis_reg ? frac_y_reg : frac_x_reg;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        prev_left_next  = prev_left_reg;
        prev_right_next = prev_right_reg;
        heading_next    = heading_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        frac_x_next     = frac_x_reg;
        frac_y_next     = frac_y_reg;
        axis_next       = axis_reg;
        m_tvalid_next   = m_tvalid_reg;
        diff_next       = diff_reg;
        sum_next        = sum_reg;
        dmag_next       = dmag_reg;
        step_next       = step_reg;
        acc_next        = acc_reg;
        out_load        = 1'b0;

        // drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (in_kind == KIND_CLEAR) begin
                        prev_left_next  = '0;
                        prev_right_next = '0;
                        state_next      = S_OUT;
                    end else begin
                        prev_left_next  = in_left;
                        prev_right_next = in_right;
                        diff_next       = 33'(dr) - 33'(dl);
                        sum_next        = 33'(dl) + 33'(dr);
                        state_next      = S_HGO;
                    end
                end
            end
            S_HGO: begin
                state_next = S_HWAIT;
            end
            S_HWAIT: begin
                if (!mul_busy) begin
                    heading_next = heading_reg - mul_prod[HEAD_MSB:HEAD_LSB];
                    state_next   = S_TGO;
                end
            end
            S_TGO: begin
                state_next = S_TWAIT;
            end
            S_TWAIT: begin
                if (!mul_busy && !cor_busy) begin
                    dmag_next  = mul_prod[DMAG_MSB:DMAG_LSB];
                    axis_next  = 1'b0;
                    state_next = S_SGO;
                end
            end
            S_SGO: begin
                state_next = S_SWAIT;
            end
            S_SWAIT: begin
                if (!mul_busy) begin
                    step_next  = (sum_reg[32] != trig_neg) ? -step_mag : step_mag;
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                acc_next   = 65'(frac_sel) + 65'(step_reg);
                state_next = S_POS;
            end
            S_POS: begin
                if (axis_reg) begin
                    pos_y_next  = pos_y_reg + whole;
                    frac_y_next = frac_new;
                    state_next  = S_OUT;
                end else begin
                    pos_x_next  = pos_x_reg + whole;
                    frac_x_next = frac_new;
                    axis_next   = 1'b1;
                    state_next  = S_SGO;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            hg_reg         <= '0;
            dg_reg         <= '0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            heading_reg    <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            frac_x_reg     <= '0;
            frac_y_reg     <= '0;
            axis_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            hg_reg         <= hg_next;
            dg_reg         <= dg_next;
            prev_left_reg  <= prev_left_next;
            prev_right_reg <= prev_right_next;
            heading_reg    <= heading_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            frac_x_reg     <= frac_x_next;
            frac_y_reg     <= frac_y_next;
            axis_reg       <= axis_next;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg <= diff_next;
        sum_reg  <= sum_next;
        dmag_reg <= dmag_next;
        step_reg <= step_next;
        acc_reg  <= acc_next;
        if (out_load) begin
            out_x_reg <= pos_x_reg;
            out_y_reg <= pos_y_reg;
            out_h_reg <= heading_reg[31:16];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_h_reg, out_y_reg, out_x_reg};

    `DDO_ASSERT_NXT(a_accept_leaves_idle, s_tvalid && s_tready, !s_tready, "request accepted but block still idle")
    `DDO_ASSERT_IMP(a_units_idle_on_launch, state_reg == S_TGO, !mul_busy && !cor_busy, "trig launch while a unit is busy")
    `DDO_ASSERT_NXT(a_clear_zeroes_prev, s_tvalid && s_tready && (in_kind == KIND_CLEAR), (prev_left_reg == '0) && (prev_right_reg == '0), "clear request left counts behind")
    `DDO_ASSERT_ALWAYS(a_frac_in_range, (frac_x_reg != FRAC_MIN) && (frac_y_reg != FRAC_MIN), "carried fraction reached one millimetre")

endmodule
